[sv/tmcr_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tmcr_pkg
// Shared constants, operation codes and control structs of the text-mode
// cell renderer.
// ---------------------------------------------------------------------------
package tmcr_pkg;

  localparam int COLUMNS      = 64;
  localparam int ROWS         = 32;
  localparam int TILE_SIZE    = 16;
  localparam int TILE_BITS    = 4;
  localparam int CELL_COUNT   = COLUMNS * ROWS;
  localparam int CELL_AW      = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
  localparam int SCREEN_W     = COLUMNS * TILE_SIZE;
  localparam int SCREEN_H     = ROWS * TILE_SIZE;
  localparam int GLYPH_ROWS   = 4096;
  localparam int GLYPH_AW     = 12;
  localparam int PALETTE_SIZE = 16;
  localparam int PAL_AW       = 4;
  localparam int CELL_W       = 16;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hff;

  typedef enum logic [2:0] {
    OP_WRITE_CELL   = 3'd0,
    OP_CLEAR        = 3'd1,
    OP_READ_PIXEL   = 3'd2,
    OP_LOAD_FONT    = 3'd3,
    OP_LOAD_PALETTE = 3'd4
  } op_t;

  typedef struct packed {
    logic cell_wr;
    logic cell_rd;
    logic clear_init;
    logic clear_step;
    logic glyph_wr;
    logic glyph_rd;
    logic pal_wr;
    logic pal_rd;
    logic args_load;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
  } stat_t;

endpackage

[sv/tmcr_ram.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tmcr_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module tmcr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[sv/tmcr_ctrl.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tmcr_ctrl
// Sequencer: decodes accepted words, runs the three-read pixel lookup and
// the grid clear sweep.
// ---------------------------------------------------------------------------
module tmcr_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [2:0]     in_operation,
  input  tmcr_pkg::stat_t stat,
  output tmcr_pkg::cmd_t  cmd,
  output logic           busy
);
  import tmcr_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_GLYPH,
    S_PALETTE,
    S_FINISH,
    S_CLEAR
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r;
  logic   accept;
  op_t    op;

  assign op     = op_t'(in_operation);
  assign accept = start && !busy_r;
  assign busy   = busy_r;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (op)
            OP_WRITE_CELL:   cmd.cell_wr = 1'b1;
            OP_CLEAR: begin
              cmd.clear_init = 1'b1;
              state_nxt      = S_CLEAR;
            end
            OP_READ_PIXEL: begin
              cmd.cell_rd   = 1'b1;
              cmd.args_load = 1'b1;
              state_nxt     = S_GLYPH;
            end
            OP_LOAD_FONT:    cmd.glyph_wr = 1'b1;
            OP_LOAD_PALETTE: cmd.pal_wr = 1'b1;
            default:         ;
          endcase
        end
      end
      S_GLYPH: begin
        cmd.glyph_rd = 1'b1;
        state_nxt    = S_PALETTE;
      end
      S_PALETTE: begin
        cmd.pal_rd = 1'b1;
        state_nxt  = S_FINISH;
      end
      S_FINISH: begin
        cmd.out_load = 1'b1;
        state_nxt    = S_IDLE;
      end
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (stat.clear_last) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      busy_r  <= 1'b1;
    end else begin
      state_r <= state_nxt;
      busy_r  <= (state_nxt != S_IDLE);
    end
  end

endmodule

[sv/tmcr_datapath.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tmcr_datapath
// Cell, glyph and palette stores, clear sweep counter, pixel lookup and
// result register.
// ---------------------------------------------------------------------------
module tmcr_datapath (
  input  logic            clk,
  input  logic            rst_n,
  input  tmcr_pkg::cmd_t  cmd,
  output tmcr_pkg::stat_t stat,
  input  logic [6:0]      in_cell_col,
  input  logic [5:0]      in_cell_row,
  input  logic [7:0]      in_symbol_code,
  input  logic [7:0]      in_attribute,
  input  logic [10:0]     in_pixel_x,
  input  logic [9:0]      in_pixel_y,
  input  logic [11:0]     in_font_row_addr,
  input  logic [15:0]     in_font_row_bits,
  input  logic [3:0]      in_palette_index,
  input  logic [23:0]     in_palette_rgb,
  output logic            out_valid,
  output logic [31:0]     out_pixel_argb,
  output logic            out_on_screen
);
  import tmcr_pkg::*;

  logic [CELL_AW-1:0]   clr_cnt_r;
  logic [7:0]           clr_attr_r;
  logic [TILE_BITS-1:0] px_lo_r;
  logic [TILE_BITS-1:0] py_lo_r;
  logic                 on_r;
  logic                 out_valid_r;
  logic [31:0]          out_argb_r;
  logic                 out_on_r;

  logic                 wr_in_bounds;
  logic                 pix_in_bounds;
  logic [CELL_AW-1:0]   wr_addr;
  logic [CELL_AW-1:0]   rd_addr;
  logic                 cell_we;
  logic [CELL_AW-1:0]   cell_waddr;
  logic [CELL_W-1:0]    cell_wdata;
  logic [CELL_W-1:0]    cell_q;
  logic [15:0]          glyph_q;
  logic [23:0]          pal_q;
  logic [GLYPH_AW-1:0]  glyph_raddr;
  logic                 lit;
  logic [PAL_AW-1:0]    pal_raddr;

  assign wr_in_bounds  = (32'(in_cell_col) < 32'(COLUMNS)) && (32'(in_cell_row) < 32'(ROWS));
  assign pix_in_bounds = (32'(in_pixel_x) < 32'(SCREEN_W)) && (32'(in_pixel_y) < 32'(SCREEN_H));

  assign wr_addr = CELL_AW'(32'(in_cell_row) * 32'(COLUMNS) + 32'(in_cell_col));
  assign rd_addr = CELL_AW'(32'(in_pixel_y[9:TILE_BITS]) * 32'(COLUMNS)
                            + 32'(in_pixel_x[10:TILE_BITS]));

  // clear sweep takes the write port over
  assign cell_we    = cmd.clear_step || (cmd.cell_wr && wr_in_bounds);
  assign cell_waddr = cmd.clear_step ? clr_cnt_r : wr_addr;
  assign cell_wdata = cmd.clear_step ? {8'h00, clr_attr_r} : {in_symbol_code, in_attribute};

  assign stat.clear_last = (32'(clr_cnt_r) == 32'(CELL_COUNT - 1));

  tmcr_ram #(.WIDTH(CELL_W), .DEPTH(CELL_COUNT)) u_cell_ram (
    .clk   (clk),
    .we    (cell_we),
    .waddr (cell_waddr),
    .wdata (cell_wdata),
    .re    (cmd.cell_rd),
    .raddr (rd_addr),
    .rdata (cell_q)
  );

  assign glyph_raddr = {cell_q[15:8], py_lo_r};

  tmcr_ram #(.WIDTH(16), .DEPTH(GLYPH_ROWS)) u_glyph_ram (
    .clk   (clk),
    .we    (cmd.glyph_wr),
    .waddr (in_font_row_addr),
    .wdata (in_font_row_bits),
    .re    (cmd.glyph_rd),
    .raddr (glyph_raddr),
    .rdata (glyph_q)
  );

  assign lit       = glyph_q[px_lo_r];
  assign pal_raddr = lit ? cell_q[7:4] : cell_q[3:0];

  tmcr_ram #(.WIDTH(24), .DEPTH(PALETTE_SIZE)) u_pal_ram (
    .clk   (clk),
    .we    (cmd.pal_wr),
    .waddr (in_palette_index),
    .wdata (in_palette_rgb),
    .re    (cmd.pal_rd),
    .raddr (pal_raddr),
    .rdata (pal_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r  <= '0;
      clr_attr_r <= '0;
    end else if (cmd.clear_init) begin
      clr_cnt_r  <= '0;
      clr_attr_r <= in_attribute;
    end else if (cmd.clear_step) begin
      clr_cnt_r  <= clr_cnt_r + CELL_AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.args_load) begin
      px_lo_r <= in_pixel_x[TILE_BITS-1:0];
      py_lo_r <= in_pixel_y[TILE_BITS-1:0];
      on_r    <= pix_in_bounds;
    end
    if (cmd.out_load) begin
      out_argb_r <= on_r ? {ALPHA_OPAQUE, pal_q} : 32'h0;
      out_on_r   <= on_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.out_load;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_pixel_argb = out_argb_r;
  assign out_on_screen  = out_on_r;

endmodule

[sv/text_mode_cell_renderer_unit.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// text_mode_cell_renderer_unit
// Text-mode character generator: cell grid, font and palette stores with
// pixel lookup.
// ---------------------------------------------------------------------------
// Pixel read: out_valid strobes after the chained cell, glyph and palette
//   reads; busy until the result loads, so one read is taken at a time.
// Cell write, font row load, palette load: never busy, back to back.
// Clear: busy while all COLUMNS*ROWS cells (2048) are written, one cell written per cycle.
// Reset: runs the same clear sweep with attribute 0, busy until it ends.
// Results cannot be stalled; each is valid for exactly one cycle.
module text_mode_cell_renderer_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_operation,
  input  logic [6:0]  in_cell_col,
  input  logic [5:0]  in_cell_row,
  input  logic [7:0]  in_symbol_code,
  input  logic [7:0]  in_attribute,
  input  logic [10:0] in_pixel_x,
  input  logic [9:0]  in_pixel_y,
  input  logic [11:0] in_font_row_addr,
  input  logic [15:0] in_font_row_bits,
  input  logic [3:0]  in_palette_index,
  input  logic [23:0] in_palette_rgb,
  output logic        out_valid,
  output logic [31:0] out_pixel_argb,
  output logic        out_on_screen
);
  import tmcr_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  tmcr_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .in_operation (in_operation),
    .stat         (stat),
    .cmd          (cmd),
    .busy         (busy)
  );

  tmcr_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_cell_col      (in_cell_col),
    .in_cell_row      (in_cell_row),
    .in_symbol_code   (in_symbol_code),
    .in_attribute     (in_attribute),
    .in_pixel_x       (in_pixel_x),
    .in_pixel_y       (in_pixel_y),
    .in_font_row_addr (in_font_row_addr),
    .in_font_row_bits (in_font_row_bits),
    .in_palette_index (in_palette_index),
    .in_palette_rgb   (in_palette_rgb),
    .out_valid        (out_valid),
    .out_pixel_argb   (out_pixel_argb),
    .out_on_screen    (out_on_screen)
  );

  a_read_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_operation == OP_READ_PIXEL)) |=> busy)
    else $error("pixel read accepted without going busy");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held longer than one cycle");

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while still busy");

  a_offscreen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_on_screen) |-> (out_pixel_argb == 32'h0))
    else $error("off-screen pixel with nonzero color");

  a_clear_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_operation == OP_CLEAR)) |=> (busy && !out_valid))
    else $error("clear accepted without going busy");

endmodule
